// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the event selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/twes_pkg.sv =====
// ----------------------------------------------------------------------------
// twes_pkg
// Shared types and constants of the two-level weighted event selector.
// ----------------------------------------------------------------------------
package twes_pkg;
  localparam int unsigned MaxGroupsDef  = 16;
  localparam int unsigned MaxStepsDef   = 64;
  localparam int unsigned WeightBitsDef = 32;
  localparam int unsigned AccBits       = 40;

  localparam logic [1:0] OpLoadGroup = 2'd0;
  localparam logic [1:0] OpLoadStep  = 2'd1;
  localparam logic [1:0] OpSelect    = 2'd2;

  localparam logic RegCompCount = 1'b0;
  localparam logic RegPathCount = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic start;      // latch select operands, clear sum and counters
    logic mul_hi;     // compute high partial product
    logic mul_lo;     // compute low partial product, load high product into target
    logic rd_group;   // issue group table read
    logic add_group;  // accumulate group weight and compare
    logic back_out;   // remove group weight, load step count
    logic rd_step;    // issue step table read
    logic add_step;   // accumulate step weight and compare
    logic next_group; // advance group index
    logic to_paths;   // switch to path table, group 0
    logic commit;     // record hit as last selection
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic group_done; // no groups left in current table
    logic table_path; // scanning path table
    logic hit;        // running sum exceeds target
    logic steps_done; // no steps left in current group
  } sts_t;
endpackage

// ===== rtl/twes_datapath.sv =====
// ----------------------------------------------------------------------------
// twes_datapath
// Weight tables, target multiplier, saturating accumulator and scan indices.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module twes_datapath #(
  parameter int unsigned MAX_GROUPS  = twes_pkg::MaxGroupsDef,
  parameter int unsigned MAX_STEPS   = twes_pkg::MaxStepsDef,
  parameter int unsigned WEIGHT_BITS = twes_pkg::WeightBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  logic [1:0]     op_i,
  input  logic           kind_i,
  input  logic [3:0]     group_i,
  input  logic [5:0]     step_i,
  input  logic [31:0]    weight_i,
  input  logic [6:0]     step_count_i,
  input  logic [31:0]    random_fraction_i,
  input  logic [39:0]    total_weight_i,
  input  logic [4:0]     comp_count_i,
  input  logic [4:0]     path_count_i,
  input  twes_pkg::ctl_t ctl_i,
  output twes_pkg::sts_t sts_o,
  output logic           sel_kind_o,
  output logic [3:0]     sel_group_o,
  output logic [5:0]     sel_step_o
);
  import twes_pkg::*;

  localparam int unsigned GB = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned SB = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned CB = $clog2(MAX_STEPS + 1);
  localparam int unsigned GCB = $clog2(MAX_GROUPS + 1);
  localparam int unsigned GD = MAX_GROUPS;
  localparam int unsigned SD = MAX_GROUPS * MAX_STEPS;
  localparam int unsigned SAB = GB + SB;
  localparam logic [AccBits-1:0] AccMax = {AccBits{1'b1}};

  logic [WEIGHT_BITS-1:0] gw_mem [2*GD];
  logic [CB-1:0]          sc_mem [2*GD];
  logic [WEIGHT_BITS-1:0] sw_mem [2*SD];

  // load path
  logic [CB-1:0] cnt_clip;
  logic          grp_ok, stp_ok;
  always_comb begin
    if ({25'd0, step_count_i} > 32'(MAX_STEPS)) cnt_clip = CB'(MAX_STEPS);
    else cnt_clip = CB'(step_count_i);
    grp_ok = {28'd0, group_i} < 32'(MAX_GROUPS);
    stp_ok = {26'd0, step_i} < 32'(MAX_STEPS);
  end

  logic [GB:0]  gw_wa;
  logic [SAB:0] sw_wa;
  assign gw_wa = {kind_i, GB'(group_i)};
  assign sw_wa = {kind_i, GB'(group_i), SB'(step_i)};

  always_ff @(posedge clk_i) begin
    if (load_i && op_i == OpLoadGroup && grp_ok) begin
      gw_mem[gw_wa] <= weight_i[WEIGHT_BITS-1:0];
      sc_mem[gw_wa] <= cnt_clip;
    end
    if (load_i && op_i == OpLoadStep && grp_ok && stp_ok) begin
      sw_mem[sw_wa] <= weight_i[WEIGHT_BITS-1:0];
    end
  end

  // scan state
  logic                   tbl_q;
  logic [GCB-1:0]         g_q;
  logic [CB-1:0]          s_q;
  logic [CB-1:0]          ns_q;
  logic [AccBits-1:0]     sum_q, target_q;
  logic [31:0]            rnd_q;
  logic [39:0]            tot_q;
  logic [63:0]            prod_q;
  logic [WEIGHT_BITS-1:0] gw_rd_q, sw_rd_q;
  logic [CB-1:0]          sc_rd_q;
  logic                   last_kind_q;
  logic [3:0]             last_group_q;
  logic [5:0]             last_step_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_group) begin
      gw_rd_q <= gw_mem[{tbl_q, g_q[GB-1:0]}];
      sc_rd_q <= sc_mem[{tbl_q, g_q[GB-1:0]}];
    end
    if (ctl_i.rd_step) sw_rd_q <= sw_mem[{tbl_q, g_q[GB-1:0], s_q[SB-1:0]}];
  end

  logic [GCB-1:0] n_groups;
  logic [4:0]     cnt_sel;
  always_comb begin
    cnt_sel = tbl_q ? path_count_i : comp_count_i;
    if (32'(cnt_sel) > 32'(MAX_GROUPS)) n_groups = GCB'(MAX_GROUPS);
    else n_groups = GCB'(cnt_sel);
  end

  logic [AccBits:0]   add_g, add_s;
  logic [AccBits-1:0] sat_g, sat_s;
  always_comb begin
    add_g = {1'b0, sum_q} + (AccBits + 1)'(gw_rd_q);
    add_s = {1'b0, sum_q} + (AccBits + 1)'(sw_rd_q);
    sat_g = add_g[AccBits] ? AccMax : add_g[AccBits-1:0];
    sat_s = add_s[AccBits] ? AccMax : add_s[AccBits-1:0];
  end

  logic hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_q        <= 1'b0;
      g_q          <= '0;
      s_q          <= '0;
      hit_q        <= 1'b0;
      last_kind_q  <= 1'b0;
      last_group_q <= '0;
      last_step_q  <= '0;
    end else begin
      if (ctl_i.start) begin
        tbl_q <= 1'b0;
        g_q   <= '0;
        hit_q <= 1'b0;
      end
      if (ctl_i.to_paths) begin
        tbl_q <= 1'b1;
        g_q   <= '0;
      end
      if (ctl_i.next_group) g_q <= g_q + 1'b1;
      if (ctl_i.add_group) hit_q <= sat_g > target_q;
      if (ctl_i.back_out) begin
        s_q   <= '0;
        hit_q <= 1'b0;
      end
      if (ctl_i.add_step) begin
        hit_q <= sat_s > target_q;
        if (!(sat_s > target_q)) s_q <= s_q + 1'b1;
      end
      if (ctl_i.commit) begin
        last_kind_q  <= tbl_q;
        last_group_q <= 4'(g_q);
        last_step_q  <= 6'(s_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rnd_q <= random_fraction_i;
      tot_q <= total_weight_i;
      sum_q <= '0;
    end
    // target = rnd*hi + (rnd*lo >> 32), two 32-bit products in turn
    if (ctl_i.mul_hi) prod_q <= rnd_q * {24'd0, tot_q[39:32]};
    if (ctl_i.mul_lo) begin
      target_q <= prod_q[AccBits-1:0];
      prod_q   <= rnd_q * tot_q[31:0];
    end
    if (ctl_i.rd_group && !ctl_i.mul_lo && g_q == '0 && !tbl_q)
      target_q <= target_q + AccBits'(prod_q[63:32]);
    if (ctl_i.add_group) sum_q <= sat_g;
    if (ctl_i.back_out) begin
      sum_q <= ((AccBits + 1)'(gw_rd_q) > {1'b0, sum_q}) ? '0 : sum_q - AccBits'(gw_rd_q);
      ns_q  <= sc_rd_q;
    end
    if (ctl_i.add_step) sum_q <= sat_s;
  end

  assign sts_o.group_done = g_q >= n_groups;
  assign sts_o.table_path = tbl_q;
  assign sts_o.hit        = hit_q;
  assign sts_o.steps_done = s_q >= ns_q;
  assign sel_kind_o  = last_kind_q;
  assign sel_group_o = last_group_q;
  assign sel_step_o  = last_step_q;

  `ASSERT_NEXT(a_commit_holds, clk_i, rst_ni, ctl_i.commit, sel_kind_o == $past(tbl_q))
  `ASSERT_IMPLY(a_no_both_adds, clk_i, rst_ni, 1'b1, !(ctl_i.add_group && ctl_i.add_step))
  `ASSERT_NEXT(a_paths_restart, clk_i, rst_ni, ctl_i.to_paths, tbl_q && g_q == '0)
endmodule

// ===== rtl/twes_ctrl.sv =====
// ----------------------------------------------------------------------------
// twes_ctrl
// Scan sequencer: handshake, multiply steps, group scan, step scan, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module twes_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     op_i,
  output logic           load_o,
  output twes_pkg::ctl_t ctl_o,
  input  twes_pkg::sts_t sts_i,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           found_o
);
  import twes_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MHI, S_MLO, S_GRD, S_GADD, S_GCHK, S_BACK,
    S_SRD, S_SADD, S_SCHK, S_DONE
  } state_e;

  state_e state_q;
  logic   found_q, ovalid_q;
  logic   accept;

  assign in_stall = (state_q != S_IDLE) || (ovalid_q && out_stall);
  assign accept   = in_valid && !in_stall;
  assign load_o   = accept && op_i != OpSelect;

  always_comb begin
    ctl_o = '0;
    ctl_o.start      = accept && op_i == OpSelect;
    ctl_o.mul_hi     = state_q == S_MHI;
    ctl_o.mul_lo     = state_q == S_MLO;
    ctl_o.rd_group   = state_q == S_GRD;
    ctl_o.add_group  = state_q == S_GADD;
    ctl_o.back_out   = state_q == S_GCHK && sts_i.hit;
    ctl_o.next_group = state_q == S_GCHK && !sts_i.hit;
    ctl_o.rd_step    = state_q == S_SRD;
    ctl_o.add_step   = state_q == S_SADD;
    ctl_o.commit     = state_q == S_SCHK && sts_i.hit;
    ctl_o.to_paths   = (state_q == S_GRD && sts_i.group_done && !sts_i.table_path) ||
                       (state_q == S_SCHK && !sts_i.hit && sts_i.steps_done &&
                        !sts_i.table_path);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (ctl_o.start) state_q <= S_MHI;
        S_MHI:  state_q <= S_MLO;
        S_MLO:  state_q <= S_GRD;
        S_GRD: begin
          if (sts_i.group_done) begin
            if (sts_i.table_path) begin
              found_q <= 1'b0;
              state_q <= S_DONE;
            end
            // stay: table switched to paths
          end else begin
            state_q <= S_GADD;
          end
        end
        S_GADD: state_q <= S_GCHK;
        S_GCHK: state_q <= sts_i.hit ? S_SRD : S_GRD;
        S_SRD: begin
          if (sts_i.steps_done) begin
            if (sts_i.table_path) begin
              found_q <= 1'b0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCHK;
            end
          end else begin
            state_q <= S_SADD;
          end
        end
        S_SADD: state_q <= S_SCHK;
        S_SCHK: begin
          if (sts_i.hit) begin
            found_q <= 1'b1;
            state_q <= S_DONE;
          end else if (sts_i.steps_done) begin
            if (sts_i.table_path) begin
              found_q <= 1'b0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_GRD;
            end
          end else begin
            state_q <= S_SRD;
          end
        end
        S_DONE: begin
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ovalid_q;
  assign found_o   = found_q;

  `ASSERT_IMPLY(a_busy_stalls, clk_i, rst_ni, state_q != S_IDLE, in_stall)
  `ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == S_DONE, out_valid)
  `ASSERT_IMPLY(a_one_step_op, clk_i, rst_ni, 1'b1,
                $countones({ctl_o.rd_group, ctl_o.add_group, ctl_o.rd_step,
                            ctl_o.add_step}) <= 1)
endmodule

// ===== rtl/two_level_weighted_event_select_top.sv =====
// A select first forms the target from the high and low partial products, then scans the
// compartment table, on a miss the path table, group by group, and the hit group's steps.
// Each entry is read, added and compared in turn.
// Throughput: one item at a time; input stalls while a select runs or its result is stalled.
// Reset: asynchronous, active low; clears control, counts and last selection.
// Weight tables are undefined until loaded.
// ----------------------------------------------------------------------------
// two_level_weighted_event_select_top
// Direct-method event picker over compartment and transfer path tables.
// ----------------------------------------------------------------------------
module two_level_weighted_event_select_top #(
  parameter int unsigned MAX_GROUPS  = twes_pkg::MaxGroupsDef,
  parameter int unsigned MAX_STEPS   = twes_pkg::MaxStepsDef,
  parameter int unsigned WEIGHT_BITS = twes_pkg::WeightBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op_i,
  input  logic        kind_i,
  input  logic [3:0]  group_i,
  input  logic [5:0]  step_i,
  input  logic [31:0] weight_i,
  input  logic [6:0]  step_count_i,
  input  logic [31:0] random_fraction_i,
  input  logic [39:0] total_weight_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found_o,
  output logic        sel_kind_o,
  output logic [3:0]  sel_group_o,
  output logic [5:0]  sel_step_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  import twes_pkg::*;

  logic [4:0] comp_count_q, path_count_q;
  logic       load;
  ctl_t       ctl;
  sts_t       sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_count_q <= '0;
      path_count_q <= '0;
    end else if (cfg_valid) begin
      if (cfg_index_i == RegCompCount) comp_count_q <= cfg_data_i;
      if (cfg_index_i == RegPathCount) path_count_q <= cfg_data_i;
    end
  end

  twes_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .op_i, .load_o(load),
    .ctl_o(ctl), .sts_i(sts), .out_valid, .out_stall, .found_o
  );

  twes_datapath #(
    .MAX_GROUPS(MAX_GROUPS), .MAX_STEPS(MAX_STEPS), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .load_i(load), .op_i, .kind_i, .group_i, .step_i, .weight_i,
    .step_count_i, .random_fraction_i, .total_weight_i,
    .comp_count_i(comp_count_q), .path_count_i(path_count_q),
    .ctl_i(ctl), .sts_o(sts), .sel_kind_o, .sel_group_o, .sel_step_o
  );
endmodule
